FILE: rtl/mcp_pkg.sv
package mcp_pkg;

  // fixed field widths
  localparam int unsigned ADDR_W    = 14;
  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned LEN_W     = 15;
  localparam int unsigned OUT_W     = 24;
  localparam int unsigned LEVEL_W   = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 18;

  // period division: sample_rate * 960 over subdivision * tempo_bpm_x16
  localparam int unsigned NUM_W    = 28;
  localparam int unsigned DEN_W    = 15;
  localparam int unsigned PERIOD_W = 22;
  localparam logic [PERIOD_W-1:0] PERIOD_MAX = 22'h3FFFFF;

  // shared multiplier operand and product widths
  localparam int unsigned MUL_A_W = 33;
  localparam int unsigned MUL_B_W = 17;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WAVE_SELECT = 3'd0,
    REG_TEMPO       = 3'd1,
    REG_SUBDIVISION = 3'd2,
    REG_SAMPLE_RATE = 3'd3,
    REG_VOLUME      = 3'd4,
    REG_TONE        = 3'd5
  } cfg_reg_t;

  // divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

FILE: rtl/mcp_ram.sv
module mcp_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

endmodule

FILE: rtl/mcp_mul.sv
module mcp_mul import mcp_pkg::*; (
  input  logic                      clk,
  input  logic                      en,
  input  logic signed [MUL_A_W-1:0] a,
  input  logic signed [MUL_B_W-1:0] b,
  output logic signed [MUL_P_W-1:0] p_r
);

  // one signed product per cycle, held while not enabled
  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= MUL_P_W'(a) * MUL_P_W'(b);
    end
  end

endmodule

FILE: rtl/mcp_div.sv
module mcp_div import mcp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0] quo,
  output div_stat_t        stat
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [NUM_W-1:0] quo_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W:0]   shifted;
  logic [DEN_W+1:0] trial;

  // restoring division, one quotient bit per cycle
  assign shifted = {rem_r, quo_r[NUM_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt_r <= CNT_W'(NUM_W);
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      cnt_r <= cnt_r - CNT_W'(1);
      if (!trial[DEN_W+1]) begin
        rem_r <= trial[DEN_W-1:0];
        quo_r <= {quo_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_r <= shifted[DEN_W-1:0];
        quo_r <= {quo_r[NUM_W-2:0], 1'b0};
      end
    end
  end

  assign quo       = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

FILE: rtl/metronome_click_player.sv
// Metronome click player. Load words (in_tuser high) write one 16-bit sample into one of
// WAVE_COUNT click waves of WAVE_DEPTH samples each, and in_tlast on a load sets that wave's
// length to address plus one; loads give no output and leave the player idle. Tick words
// (in_tuser low) give one output word each: the selected wave, replayed from its start at every
// beat subdivision, scaled by volume squared, passed through a one-pole lowpass driven by tone,
// saturated to Q1.23; out_tuser flags the tick that started a new click. A tick's result is
// registered after its read, two multiply and filter steps, the last stalling on an unread
// prior word; no word is taken meanwhile. A beat's first tick waits on the 28-step bit-serial
// divider for the period. The three products of a tick go one after another through a single
// 33x17 multiplier. Wave entries never written read back as garbage, so load every played
// sample first. Configuration writes are always ready and belong in idle time only.
module metronome_click_player import mcp_pkg::*; #(
  parameter int unsigned WAVE_DEPTH = 16384,
  parameter int unsigned WAVE_COUNT = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // input stream
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [31:0]          in_tdata,   // wave_id[1:0], address[15:2], sample[31:16]
  input  logic                 in_tuser,   // mode: 0 tick, 1 load
  input  logic                 in_tlast,   // last_sample
  // output stream
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [23:0]          out_tdata,  // out_sample[23:0]
  output logic                 out_tuser,  // beat_start
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  localparam int unsigned RAM_DEPTH = WAVE_COUNT * WAVE_DEPTH;
  localparam int unsigned RAM_AW    = $clog2(RAM_DEPTH);
  localparam int unsigned DEPTH_W   = $clog2(WAVE_DEPTH + 1);

  localparam logic signed [35:0] LEVEL_HI = 36'sd2147483647;
  localparam logic signed [35:0] LEVEL_LO = -36'sd2147483648;
  localparam logic signed [31:0] OUT_HI   = 32'sd8388607;
  localparam logic signed [31:0] OUT_LO   = -32'sd8388608;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_RD,
    S_MUL1,
    S_MUL2,
    S_FILT
  } state_t;

  // input word fields
  logic                       f_mode;
  logic [1:0]                 f_wave_id;
  logic [ADDR_W-1:0]          f_address;
  logic [SAMPLE_W-1:0]        f_sample;
  logic                       f_last;

  // state and registers
  state_t                     state_r, state_nxt;
  logic [1:0]                 wave_select_r, wave_select_nxt;
  logic [11:0]                tempo_r, tempo_nxt;
  logic [2:0]                 subdiv_r, subdiv_nxt;
  logic [17:0]                sample_rate_r, sample_rate_nxt;
  logic [15:0]                volume_r, volume_nxt;
  logic [15:0]                tone_r, tone_nxt;
  logic [LEN_W-1:0]           wave_len_r [WAVE_COUNT];
  logic [LEN_W-1:0]           wave_len_nxt [WAVE_COUNT];
  logic [PERIOD_W-1:0]        countdown_r, countdown_nxt;
  logic [LEN_W-1:0]           position_r, position_nxt;
  logic signed [LEVEL_W-1:0]  level_r, level_nxt;
  logic                       beat_r, beat_nxt;
  logic                       play_r, play_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]           out_data_r, out_data_nxt;
  logic                       out_user_r, out_user_nxt;

  // datapath
  logic                       in_acc;
  logic                       load_ok;
  logic [LEN_W-1:0]           sel_len;
  logic                       sel_ok;
  logic [2:0]                 subdiv_eff;
  logic [DEN_W-1:0]           den;
  logic [NUM_W-1:0]           num;
  logic                       div_start;
  logic [NUM_W-1:0]           quo;
  logic [PERIOD_W-1:0]        period;
  div_stat_t                  div_stat;
  logic                       ram_we;
  logic [RAM_AW-1:0]          ram_addr;
  logic [SAMPLE_W-1:0]        ram_rdata;
  logic                       mul_en;
  logic signed [MUL_A_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0]  mul_b;
  logic signed [MUL_P_W-1:0]  prod;
  logic signed [MUL_A_W-1:0]  x_val;
  logic signed [MUL_A_W-1:0]  diff;
  logic signed [35:0]         level_sum;
  logic signed [LEVEL_W-1:0]  level_sat;

  assign f_mode    = in_tuser;
  assign f_wave_id = in_tdata[1:0];
  assign f_address = in_tdata[15:2];
  assign f_sample  = in_tdata[31:16];
  assign f_last    = in_tlast;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // loads outside the stores are dropped, last flag too
  assign load_ok = in_acc && f_mode
                && ({30'd0, f_wave_id} < 32'(WAVE_COUNT))
                && (DEPTH_W'(f_address) < DEPTH_W'(WAVE_DEPTH))
                && ({{(32-ADDR_W){1'b0}}, f_address} < 32'(WAVE_DEPTH));

  // length of the selected wave, zero when no such wave
  always_comb begin
    sel_len = '0;
    for (int i = 0; i < WAVE_COUNT; i++) begin
      if (wave_select_r == 2'(i)) begin
        sel_len = wave_len_r[i];
      end
    end
  end
  assign sel_ok = ({30'd0, wave_select_r} < 32'(WAVE_COUNT)) && (position_r < sel_len);

  // beat period operands: rate * 960 as two shifts
  assign subdiv_eff = (subdiv_r == 3'd0) ? 3'd1 : subdiv_r;
  assign den        = DEN_W'(subdiv_eff) * DEN_W'(tempo_r);
  assign num        = (NUM_W'(sample_rate_r) << 10) - (NUM_W'(sample_rate_r) << 6);
  assign div_start  = in_acc && !f_mode && (countdown_r == '0) && (den != '0);

  always_comb begin
    if (quo > NUM_W'(PERIOD_MAX)) begin
      period = PERIOD_MAX;
    end else if (quo == '0) begin
      period = PERIOD_W'(1);
    end else begin
      period = quo[PERIOD_W-1:0];
    end
  end

  mcp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num),
    .den   (den),
    .quo   (quo),
    .stat  (div_stat)
  );

  // wave store: written by loads in idle, read once per tick
  assign ram_we   = load_ok;
  assign ram_addr = (state_r == S_RD)
                  ? RAM_AW'(wave_select_r) * RAM_AW'(WAVE_DEPTH) + RAM_AW'(position_r)
                  : RAM_AW'(f_wave_id) * RAM_AW'(WAVE_DEPTH) + RAM_AW'(f_address);

  mcp_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .addr    (ram_addr),
    .wdata   (f_sample),
    .rdata_r (ram_rdata)
  );

  // shared multiplier: volume squared, times sample, then tone times filter error
  assign x_val = play_r ? MUL_A_W'($signed(prod[MUL_P_W-1:22])) : '0;
  assign diff  = x_val - MUL_A_W'(level_r);

  always_comb begin
    mul_en = 1'b0;
    mul_a  = $signed({17'd0, volume_r});
    mul_b  = $signed({1'b0, volume_r});
    unique case (state_r)
      S_RD: begin
        mul_en = 1'b1;
      end
      S_MUL1: begin
        mul_en = 1'b1;
        mul_a  = $signed({1'b0, prod[31:0]});
        mul_b  = $signed({ram_rdata[SAMPLE_W-1], ram_rdata});
      end
      S_MUL2: begin
        mul_en = 1'b1;
        mul_a  = diff;
        mul_b  = $signed({1'b0, tone_r});
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  mcp_mul u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (prod)
  );

  // lowpass update with saturation of the level
  assign level_sum = 36'(level_r) + 36'($signed(prod[MUL_P_W-1:15]));

  always_comb begin
    if (level_sum > LEVEL_HI) begin
      level_sat = 32'sh7FFFFFFF;
    end else if (level_sum < LEVEL_LO) begin
      level_sat = -32'sh80000000;
    end else begin
      level_sat = level_sum[31:0];
    end
  end

  // sequencer
  always_comb begin
    state_nxt       = state_r;
    wave_select_nxt = wave_select_r;
    tempo_nxt       = tempo_r;
    subdiv_nxt      = subdiv_r;
    sample_rate_nxt = sample_rate_r;
    volume_nxt      = volume_r;
    tone_nxt        = tone_r;
    wave_len_nxt    = wave_len_r;
    countdown_nxt   = countdown_r;
    position_nxt    = position_r;
    level_nxt       = level_r;
    beat_nxt        = beat_r;
    play_nxt        = play_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_data_nxt    = out_data_r;
    out_user_nxt    = out_user_r;

    if (cfg_valid) begin
      unique case (cfg_index)
        REG_WAVE_SELECT: wave_select_nxt = cfg_data[1:0];
        REG_TEMPO:       tempo_nxt       = cfg_data[11:0];
        REG_SUBDIVISION: subdiv_nxt      = cfg_data[2:0];
        REG_SAMPLE_RATE: sample_rate_nxt = cfg_data;
        REG_VOLUME:      volume_nxt      = cfg_data[15:0];
        REG_TONE:        tone_nxt        = cfg_data[15:0];
        default:         ;
      endcase
    end

    if (load_ok && f_last) begin
      for (int i = 0; i < WAVE_COUNT; i++) begin
        if (f_wave_id == 2'(i)) begin
          wave_len_nxt[i] = {1'b0, f_address} + LEN_W'(1);
        end
      end
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc && !f_mode) begin
          beat_nxt = 1'b0;
          if (countdown_r == '0) begin
            if (den == '0) begin
              // zero tempo: longest period, no division
              countdown_nxt = PERIOD_MAX;
              position_nxt  = '0;
              beat_nxt      = 1'b1;
              state_nxt     = S_RD;
            end else begin
              state_nxt = S_DIV;
            end
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          countdown_nxt = period;
          position_nxt  = '0;
          beat_nxt      = 1'b1;
          state_nxt     = S_RD;
        end
      end
      S_RD: begin
        play_nxt  = sel_ok;
        state_nxt = S_MUL1;
      end
      S_MUL1: begin
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        state_nxt = S_FILT;
      end
      S_FILT: begin
        // wait here while the previous word is still unread
        if (!out_valid_r || out_tready) begin
          level_nxt     = level_sat;
          countdown_nxt = countdown_r - PERIOD_W'(1);
          if (play_r) begin
            position_nxt = position_r + LEN_W'(1);
          end
          if (level_sat > OUT_HI) begin
            out_data_nxt = 24'h7FFFFF;
          end else if (level_sat < OUT_LO) begin
            out_data_nxt = 24'h800000;
          end else begin
            out_data_nxt = level_sat[OUT_W-1:0];
          end
          out_user_nxt  = beat_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      wave_select_r <= 2'd1;
      tempo_r       <= 12'd960;
      subdiv_r      <= 3'd1;
      sample_rate_r <= 18'd48000;
      volume_r      <= 16'd16384;
      tone_r        <= 16'd32768;
      for (int i = 0; i < WAVE_COUNT; i++) begin
        wave_len_r[i] <= '0;
      end
      countdown_r   <= '0;
      position_r    <= '0;
      level_r       <= '0;
      beat_r        <= 1'b0;
      play_r        <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      wave_select_r <= wave_select_nxt;
      tempo_r       <= tempo_nxt;
      subdiv_r      <= subdiv_nxt;
      sample_rate_r <= sample_rate_nxt;
      volume_r      <= volume_nxt;
      tone_r        <= tone_nxt;
      wave_len_r    <= wave_len_nxt;
      countdown_r   <= countdown_nxt;
      position_r    <= position_nxt;
      level_r       <= level_nxt;
      beat_r        <= beat_nxt;
      play_r        <= play_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // divider only runs while the sequencer waits for it
  a_div_in_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.busy |-> (state_r == S_DIV))
    else $error("divider busy outside period step");

  // by the sample read the countdown has been reloaded
  a_countdown_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD) |-> (countdown_r != '0))
    else $error("countdown zero at sample read");

  // a fresh output word only comes out of the filter step
  a_out_from_filter: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == S_FILT))
    else $error("output word without filter step");

  // play position never runs past the longest wave
  a_position_bound: assert property (@(posedge clk) disable iff (!rst_n)
    position_r <= LEN_W'(16384))
    else $error("play position out of range");

endmodule
